@@ sv/pwpid_pkg.sv @@
// Shared types and constants for the positional PID controller.
package pwpid_pkg;

    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int SUM_W      = 32;
    localparam int OUT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OLIM     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ILIM_EN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OLIM_EN  = 3'd6;

    // Input word commands
    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIMIT_W-1:0]       ilim;
        logic [LIMIT_W-1:0]       olim;
        logic                     ilim_en;
        logic                     olim_en;
    } pwpid_cfg_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] olim;
        logic               olim_en;
        logic               clear;
    } pwpid_fmt_ctl_t;

endpackage

@@ sv/pwpid_if.sv @@
// Handshake interfaces for the sample, result and configuration channels.
interface pwpid_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic signed [SAMPLE_WIDTH-1:0] target_value;
    logic signed [SAMPLE_WIDTH-1:0] measured_value;

    modport source (output valid, output command, output target_value,
                    output measured_value, input ready);
    modport sink   (input valid, input command, input target_value,
                    input measured_value, output ready);
endinterface

interface pwpid_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] control_value;
    logic               output_clamped;

    modport source (output valid, output control_value, output output_clamped,
                    input ready);
    modport sink   (input valid, input control_value, input output_clamped,
                    output ready);
endinterface

interface pwpid_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/pwpid_out_fmt.sv @@
// Output formatting: drop the gain fraction toward zero, then clamp or saturate.
module pwpid_out_fmt
    import pwpid_pkg::*;
#(
    parameter int ACC_W     = 52,
    parameter int FRAC_BITS = 8
) (
    input  logic signed [ACC_W-1:0] acc,
    input  pwpid_fmt_ctl_t          ctl,
    output logic signed [OUT_W-1:0] control_value,
    output logic                    output_clamped
);

    localparam logic signed [ACC_W-1:0] BIAS =
        ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [ACC_W-1:0] MAX32 =
        {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN32 =
        {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] trunc;
    logic signed [ACC_W-1:0] lim;
    logic signed [ACC_W-1:0] neg_lim;
    logic signed [ACC_W-1:0] clamped;
    logic                    hit;

    always_comb
    begin
        // Bias negative values so the arithmetic shift rounds toward zero
        biased  = acc + (acc[ACC_W-1] ? BIAS : '0);
        trunc   = biased >>> FRAC_BITS;
        lim     = {{(ACC_W-LIMIT_W){1'b0}}, ctl.olim};
        neg_lim = -lim;
        clamped = trunc;
        hit     = 1'b0;
        if (ctl.olim_en)
        begin
            if (trunc > lim)
            begin
                clamped = lim;
                hit     = 1'b1;
            end
            else if (trunc < neg_lim)
            begin
                clamped = neg_lim;
                hit     = 1'b1;
            end
        end
        else
        begin
            if (trunc > MAX32)
            begin
                clamped = MAX32;
                hit     = 1'b1;
            end
            else if (trunc < MIN32)
            begin
                clamped = MIN32;
                hit     = 1'b1;
            end
        end
        if (ctl.clear)
        begin
            control_value  = '0;
            output_clamped = 1'b0;
        end
        else
        begin
            control_value  = clamped[OUT_W-1:0];
            output_clamped = hit;
        end
    end

endmodule

@@ sv/positional_pid_with_clamps.sv @@
// Positional PID controller with integral and output clamps (top level).
//
// Each sample word forms error = target_value - measured_value, adds it to a
// running error sum (saturated at signed 32 bits, then optionally clamped to
// +/- integral_limit) and returns kp*e + ki*sum + kd*(e - previous e) with
// signed Q8.8 gains, the fraction dropped toward zero, clamped to
// +/- output_limit when enabled or saturated at signed 32 bits otherwise;
// output_clamped flags either case. When the error strictly changes sign the
// sum restarts from zero after the output is formed. A clear command zeroes
// the sum and the previous error and returns a zero word. The block accepts
// one sample word per cycle while the pipe is not full behind a waiting
// result. The pipeline is: input register, error and sum update (the
// error-sum feedback loop closes in this one stage, one 33-bit add, saturate
// and clamp per cycle), three gain multipliers, product sum, truncate and
// clamp into the result register. Each stage holds when the next one is full
// and cannot pass its word on, so a waiting result does not block new samples
// until the pipe fills. Configuration writes are taken every cycle and must be
// issued while no sample is in flight.
module positional_pid_with_clamps
    import pwpid_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    pwpid_cfg_if.sink      cfg,
    pwpid_sample_if.sink   sample,
    pwpid_result_if.source result
);

    localparam int EW  = SAMPLE_WIDTH + 1;             // error
    localparam int DW  = SAMPLE_WIDTH + 2;             // error difference
    localparam int AW  = ((EW > SUM_W) ? EW : SUM_W) + 1;
    localparam int PPW = GAIN_W + EW;
    localparam int PIW = GAIN_W + SUM_W;
    localparam int PDW = GAIN_W + DW;
    localparam int PW  = ((PIW > PDW) ? PIW : PDW) + 2;

    localparam logic signed [AW-1:0] SUM_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] SUM_MIN = {{(AW-31){1'b1}}, {31{1'b0}}};

    // ---------------- configuration registers ----------------
    pwpid_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp      <= '0;
            cfg_reg.ki      <= '0;
            cfg_reg.kd      <= '0;
            cfg_reg.ilim    <= '1;
            cfg_reg.olim    <= '1;
            cfg_reg.ilim_en <= 1'b0;
            cfg_reg.olim_en <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_KP:      cfg_reg.kp      <= cfg.data[GAIN_W-1:0];
                CFG_KI:      cfg_reg.ki      <= cfg.data[GAIN_W-1:0];
                CFG_KD:      cfg_reg.kd      <= cfg.data[GAIN_W-1:0];
                CFG_ILIM:    cfg_reg.ilim    <= cfg.data[LIMIT_W-1:0];
                CFG_OLIM:    cfg_reg.olim    <= cfg.data[LIMIT_W-1:0];
                CFG_ILIM_EN: cfg_reg.ilim_en <= cfg.data[0];
                CFG_OLIM_EN: cfg_reg.olim_en <= cfg.data[0];
                default:     ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- pipeline flow control ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;
    logic s1_adv, s2_adv, s3_adv, s4_adv;

    // A stage may load when it is empty or its word moves on this cycle
    assign out_ready = !out_valid_reg || result.ready;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign s1_adv = s1_valid_reg && s2_ready;
    assign s2_adv = s2_valid_reg && s3_ready;
    assign s3_adv = s3_valid_reg && s4_ready;
    assign s4_adv = s4_valid_reg && out_ready;

    assign sample.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)  s1_valid_reg  <= sample.valid;
            if (s2_ready)  s2_valid_reg  <= s1_adv;
            if (s3_ready)  s3_valid_reg  <= s2_adv;
            if (s4_ready)  s4_valid_reg  <= s3_adv;
            if (out_ready) out_valid_reg <= s4_adv;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic                           s1_clear_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_target_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_measured_reg;

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_clear_reg    <= (sample.command == CMD_CLEAR);
            s1_target_reg   <= sample.target_value;
            s1_measured_reg <= sample.measured_value;
        end
    end

    // ---------------- error and sum update (feedback state) ----------------
    logic signed [SUM_W-1:0] esum_reg, esum_next;
    logic signed [EW-1:0]    prev_reg, prev_next;
    logic signed [EW-1:0]    err;
    logic signed [DW-1:0]    err_diff;
    logic signed [AW-1:0]    sum_raw;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [SUM_W:0]   sum_wide;
    logic signed [SUM_W:0]   ilim_pos;
    logic signed [SUM_W:0]   ilim_neg;
    logic signed [SUM_W-1:0] sum_clamped;
    logic                    sign_flip;

    always_comb
    begin
        err      = EW'(s1_target_reg) - EW'(s1_measured_reg);
        err_diff = DW'(err) - DW'(prev_reg);
        sum_raw  = AW'(esum_reg) + AW'(err);

        // Saturate at signed 32 bits before the optional clamp
        if (sum_raw > SUM_MAX)
            sum_sat = SUM_MAX[SUM_W-1:0];
        else if (sum_raw < SUM_MIN)
            sum_sat = SUM_MIN[SUM_W-1:0];
        else
            sum_sat = sum_raw[SUM_W-1:0];

        sum_wide    = (SUM_W+1)'(sum_sat);
        ilim_pos    = {2'b00, cfg_reg.ilim};
        ilim_neg    = -ilim_pos;
        sum_clamped = sum_sat;
        if (cfg_reg.ilim_en)
        begin
            if (sum_wide > ilim_pos)
                sum_clamped = ilim_pos[SUM_W-1:0];
            else if (sum_wide < ilim_neg)
                sum_clamped = ilim_neg[SUM_W-1:0];
        end

        // Strict sign change only: a zero on either side never counts
        sign_flip = (err != '0) && (prev_reg != '0)
                    && (err[EW-1] != prev_reg[EW-1]);

        if (s1_clear_reg)
        begin
            esum_next = '0;
            prev_next = '0;
        end
        else
        begin
            esum_next = sign_flip ? '0 : sum_clamped;
            prev_next = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg <= '0;
            prev_reg <= '0;
        end
        else if (s1_adv)
        begin
            esum_reg <= esum_next;
            prev_reg <= prev_next;
        end
    end

    // ---------------- stage 2: operands for the gains ----------------
    logic                    s2_clear_reg;
    logic signed [EW-1:0]    s2_err_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic signed [DW-1:0]    s2_diff_reg;

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_clear_reg <= s1_clear_reg;
            s2_err_reg   <= err;
            s2_sum_reg   <= sum_clamped;  // the output uses the sum before reset
            s2_diff_reg  <= err_diff;
        end
    end

    // ---------------- stage 3: gain products ----------------
    logic                  s3_clear_reg;
    logic signed [PPW-1:0] s3_p_reg;
    logic signed [PIW-1:0] s3_i_reg;
    logic signed [PDW-1:0] s3_d_reg;

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_clear_reg <= s2_clear_reg;
            s3_p_reg     <= PPW'(cfg_reg.kp) * PPW'(s2_err_reg);
            s3_i_reg     <= PIW'(cfg_reg.ki) * PIW'(s2_sum_reg);
            s3_d_reg     <= PDW'(cfg_reg.kd) * PDW'(s2_diff_reg);
        end
    end

    // ---------------- stage 4: exact sum of products ----------------
    logic                 s4_clear_reg;
    logic signed [PW-1:0] s4_acc_reg;

    always_ff @(posedge clk)
    begin
        if (s4_ready)
        begin
            s4_clear_reg <= s3_clear_reg;
            s4_acc_reg   <= PW'(s3_p_reg) + PW'(s3_i_reg) + PW'(s3_d_reg);
        end
    end

    // ---------------- truncate, clamp, result register ----------------
    pwpid_fmt_ctl_t          fmt_ctl;
    logic signed [OUT_W-1:0] fmt_value;
    logic                    fmt_clamped;
    logic signed [OUT_W-1:0] out_value_reg;
    logic                    out_clamped_reg;

    assign fmt_ctl.olim    = cfg_reg.olim;
    assign fmt_ctl.olim_en = cfg_reg.olim_en;
    assign fmt_ctl.clear   = s4_clear_reg;

    pwpid_out_fmt #(
        .ACC_W     (PW),
        .FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out_fmt (
        .acc            (s4_acc_reg),
        .ctl            (fmt_ctl),
        .control_value  (fmt_value),
        .output_clamped (fmt_clamped)
    );

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_value_reg   <= fmt_value;
            out_clamped_reg <= fmt_clamped;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.control_value  = out_value_reg;
    assign result.output_clamped = out_clamped_reg;

    // ---------------- assertions ----------------
    // A clear leaving the update stage must leave both state words at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_clear_reg |=> esum_reg == '0 && prev_reg == '0)
        else $error("state not cleared after clear command");

    // A strict sign change restarts the error sum
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_clear_reg && sign_flip |=> esum_reg == '0)
        else $error("error sum not reset on sign change");

    // An empty input stage always takes a new word
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> sample.ready)
        else $error("input stalled while the input stage is empty");

    // The state changes only when a word leaves the update stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(esum_reg) && $stable(prev_reg))
        else $error("feedback state changed without an accepted word");

endmodule
